// File: rtl/core/tohlc_pkg.sv
// Shared types and constants for the tick to OHLC bar aggregator.
// Holds the result record, the pipeline push record and fixed codes.
// No dependencies.
`default_nettype none

package tohlc_pkg;

  localparam logic       KIND_MINUTE         = 1'b0;
  localparam logic       KIND_COARSE         = 1'b1;
  localparam logic [10:0] LAST_MINUTE_OF_DAY = 11'd1439;
  localparam logic [5:0] BARS_PER_GROUP_RESET = 6'd2;
  localparam logic [2:0] ADDR_BARS_PER_GROUP  = 3'd0;
  localparam int         QUEUE_DEPTH          = 8;

  typedef struct packed {
    logic        bar_kind;
    logic [10:0] start_minute;
    logic [30:0] open_price;
    logic [30:0] high_price;
    logic [30:0] low_price;
    logic [30:0] close_price;
    logic [31:0] bar_volume;
    logic [30:0] moving_average;
    logic        average_valid;
    logic        last_of_run;
  } result_t;

  typedef struct packed {
    logic    minute_valid;
    logic    coarse_valid;
    logic    avg_ok;
    result_t minute_bar;
    result_t coarse_bar;
  } push_t;

endpackage

`default_nettype wire

// File: rtl/core/tick_to_ohlc_bar_aggregator.sv
// Top level of the tick to OHLC bar aggregator: bar and group registers,
// coarse close shift line, APB register. Depends on tohlc_pkg and tohlc_out.
//
// Usage:
//   Ticks enter on tick_valid/tick_ready with minute_of_day, price and
//   cum_volume. Bars leave on bar_valid/bar_ready, one per transaction:
//   a one-minute bar when a tick changes minute, followed by a coarse bar
//   when that minute completes a group. last_of_run marks the final bar
//   caused by a tick.
//   Throughput: one tick per cycle while tick_ready is high. Each tick updates
//   the running bar, the group and the close shift line in the cycle it is taken.
//   The first bar of a tick passes the a and b pipeline registers and the
//   queue before it can be taken; the average is a reciprocal multiply.
//   Bars wait in an 8-entry queue. When bar_ready stays low the queue and
//   pipeline fill and tick_ready drops; it rises again as bars drain.
//   A tick that yields two bars needs two output transactions.
//   bars_per_group is at APB byte address 0 (reset 2, 0 acts as 1).
//   Write it only while the block is idle.
//   Reset clears the running bar, group, history count and queue; the
//   first tick after reset only opens a bar.
`default_nettype none

module tick_to_ohlc_bar_aggregator import tohlc_pkg::*; #(
  parameter int PERIOD = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        tick_valid,
  output logic             tick_ready,
  input  wire logic [10:0] minute_of_day,
  input  wire logic [30:0] price,
  input  wire logic [31:0] cum_volume,
  output logic             bar_valid,
  input  wire logic        bar_ready,
  output logic             bar_kind,
  output logic      [10:0] start_minute,
  output logic      [30:0] open_price,
  output logic      [30:0] high_price,
  output logic      [30:0] low_price,
  output logic      [30:0] close_price,
  output logic      [31:0] bar_volume,
  output logic      [30:0] moving_average,
  output logic             average_valid,
  output logic             last_of_run
);

  localparam int SUM_W = 31 + $clog2(PERIOD);
  localparam int HC_W  = $clog2(PERIOD + 1);

  logic [5:0]  bars_per_group;
  logic        have_bar, have_bar_next;
  logic [10:0] bar_minute, bar_minute_next;
  logic [30:0] bar_open, bar_open_next;
  logic [30:0] bar_high, bar_high_next;
  logic [30:0] bar_low, bar_low_next;
  logic [30:0] bar_close, bar_close_next;
  logic [31:0] bar_first_volume, bar_first_volume_next;
  logic [31:0] bar_last_volume, bar_last_volume_next;
  logic [5:0]  group_count, group_count_next;
  logic [10:0] group_start_minute, group_start_minute_next;
  logic [10:0] group_prev_minute, group_prev_minute_next;
  logic [30:0] group_open, group_open_next;
  logic [30:0] group_high, group_high_next;
  logic [30:0] group_low, group_low_next;
  logic [31:0] group_volume, group_volume_next;
  logic [30:0] close_history [PERIOD];
  logic [HC_W-1:0]  history_count, history_count_next;
  logic [SUM_W-1:0] close_sum, close_sum_next;

  logic        accept;
  logic        room;
  logic        shift_close;
  push_t       push;
  result_t     out_res;
  logic [31:0] closed_vol;
  logic [5:0]  need;
  logic [10:0] expect_minute;
  logic        restart;
  logic [32:0] vol_sum;
  logic [5:0]  count_inc;
  logic        coarse;
  logic        history_full;

  assign pready     = 1'b1;
  assign tick_ready = room;
  assign accept     = tick_valid && tick_ready;

  always_comb begin
    prdata = (paddr == ADDR_BARS_PER_GROUP) ? 32'(bars_per_group) : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bars_per_group <= BARS_PER_GROUP_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_BARS_PER_GROUP) begin
      bars_per_group <= pwdata[5:0];
    end
  end

  always_comb begin
    closed_vol    = (bar_last_volume >= bar_first_volume) ?
                    bar_last_volume - bar_first_volume : 32'd0;
    need          = (bars_per_group == 6'd0) ? 6'd1 : bars_per_group;
    expect_minute = (group_prev_minute == LAST_MINUTE_OF_DAY) ?
                    11'd0 : group_prev_minute + 11'd1;
    restart       = (group_count == 6'd0) || (bar_minute != expect_minute);
    vol_sum       = {1'b0, group_volume} + {1'b0, closed_vol};
    count_inc     = (restart ? 6'd0 : group_count) + 6'd1;
    coarse        = (count_inc >= need);
    history_full  = (history_count == HC_W'(PERIOD));

    have_bar_next           = have_bar;
    bar_minute_next         = bar_minute;
    bar_open_next           = bar_open;
    bar_high_next           = bar_high;
    bar_low_next            = bar_low;
    bar_close_next          = bar_close;
    bar_first_volume_next   = bar_first_volume;
    bar_last_volume_next    = bar_last_volume;
    group_count_next        = group_count;
    group_start_minute_next = group_start_minute;
    group_prev_minute_next  = group_prev_minute;
    group_open_next         = group_open;
    group_high_next         = group_high;
    group_low_next          = group_low;
    group_volume_next       = group_volume;
    history_count_next      = history_count;
    close_sum_next          = close_sum;
    shift_close             = 1'b0;
    push                    = '0;

    if (have_bar && minute_of_day == bar_minute) begin
      if (price > bar_high) begin
        bar_high_next = price;
      end
      if (price < bar_low) begin
        bar_low_next = price;
      end
      bar_close_next       = price;
      bar_last_volume_next = cum_volume;
    end else begin
      if (have_bar) begin
        if (restart) begin
          group_start_minute_next = bar_minute;
          group_open_next         = bar_open;
          group_high_next         = bar_high;
          group_low_next          = bar_low;
          group_volume_next       = closed_vol;
        end else begin
          group_high_next   = (bar_high > group_high) ? bar_high : group_high;
          group_low_next    = (bar_low < group_low) ? bar_low : group_low;
          group_volume_next = vol_sum[32] ? 32'hFFFF_FFFF : vol_sum[31:0];
        end
        group_prev_minute_next = bar_minute;
        group_count_next       = coarse ? 6'd0 : count_inc;

        push.minute_valid               = 1'b1;
        push.minute_bar.bar_kind        = KIND_MINUTE;
        push.minute_bar.start_minute    = bar_minute;
        push.minute_bar.open_price      = bar_open;
        push.minute_bar.high_price      = bar_high;
        push.minute_bar.low_price       = bar_low;
        push.minute_bar.close_price     = bar_close;
        push.minute_bar.bar_volume      = closed_vol;
        push.minute_bar.last_of_run     = !coarse;

        if (coarse) begin
          shift_close        = 1'b1;
          close_sum_next     = close_sum - (history_full ? SUM_W'(close_history[PERIOD-1])
                                                         : SUM_W'(0))
                               + SUM_W'(bar_close);
          history_count_next = history_full ? history_count : history_count + HC_W'(1);
          push.coarse_valid            = 1'b1;
          push.avg_ok                  = (history_count_next == HC_W'(PERIOD));
          push.coarse_bar.bar_kind     = KIND_COARSE;
          push.coarse_bar.start_minute = group_start_minute_next;
          push.coarse_bar.open_price   = group_open_next;
          push.coarse_bar.high_price   = group_high_next;
          push.coarse_bar.low_price    = group_low_next;
          push.coarse_bar.close_price  = bar_close;
          push.coarse_bar.bar_volume   = group_volume_next;
          push.coarse_bar.last_of_run  = 1'b1;
        end
      end
      have_bar_next         = 1'b1;
      bar_minute_next       = minute_of_day;
      bar_open_next         = price;
      bar_high_next         = price;
      bar_low_next          = price;
      bar_close_next        = price;
      bar_first_volume_next = cum_volume;
      bar_last_volume_next  = cum_volume;
    end

    if (!accept) begin
      push.minute_valid = 1'b0;
      push.coarse_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_bar           <= 1'b0;
      bar_minute         <= '0;
      bar_open           <= '0;
      bar_high           <= '0;
      bar_low            <= '0;
      bar_close          <= '0;
      bar_first_volume   <= '0;
      bar_last_volume    <= '0;
      group_count        <= '0;
      group_start_minute <= '0;
      group_prev_minute  <= '0;
      group_open         <= '0;
      group_high         <= '0;
      group_low          <= '0;
      group_volume       <= '0;
      history_count      <= '0;
      close_sum          <= '0;
    end else if (accept) begin
      have_bar           <= have_bar_next;
      bar_minute         <= bar_minute_next;
      bar_open           <= bar_open_next;
      bar_high           <= bar_high_next;
      bar_low            <= bar_low_next;
      bar_close          <= bar_close_next;
      bar_first_volume   <= bar_first_volume_next;
      bar_last_volume    <= bar_last_volume_next;
      group_count        <= group_count_next;
      group_start_minute <= group_start_minute_next;
      group_prev_minute  <= group_prev_minute_next;
      group_open         <= group_open_next;
      group_high         <= group_high_next;
      group_low          <= group_low_next;
      group_volume       <= group_volume_next;
      history_count      <= history_count_next;
      close_sum          <= close_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && shift_close) begin
      close_history[0] <= bar_close;
      for (int i = 1; i < PERIOD; i++) begin
        close_history[i] <= close_history[i-1];
      end
    end
  end

  tohlc_out #(
    .PERIOD(PERIOD)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_sum  (close_sum_next),
    .room      (room),
    .out_valid (bar_valid),
    .out_ready (bar_ready),
    .out_res   (out_res)
  );

  assign bar_kind       = out_res.bar_kind;
  assign start_minute   = out_res.start_minute;
  assign open_price     = out_res.open_price;
  assign high_price     = out_res.high_price;
  assign low_price      = out_res.low_price;
  assign close_price    = out_res.close_price;
  assign bar_volume     = out_res.bar_volume;
  assign moving_average = out_res.moving_average;
  assign average_valid  = out_res.average_valid;
  assign last_of_run    = out_res.last_of_run;

endmodule

`default_nettype wire

// File: rtl/core/tohlc_out.sv
// Result path: average divide pipeline and two-write result queue.
// Depends on tohlc_pkg for result_t, push_t and the queue depth.
// Takes up to two results per cycle, delivers one per valid/ready transaction.
`default_nettype none

module tohlc_out import tohlc_pkg::*; #(
  parameter int PERIOD = 10,
  localparam int SUM_W = 31 + $clog2(PERIOD)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire push_t            push,
  input  wire logic [SUM_W-1:0] push_sum,
  output logic                  room,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output result_t               out_res
);

  localparam int K     = SUM_W + $clog2(PERIOD);
  localparam int RW    = SUM_W + 1;
  localparam int LO_W  = SUM_W / 2;
  localparam int HI_W  = SUM_W - LO_W;
  localparam int PW    = SUM_W + RW;
  localparam logic [RW-1:0] RECIP =
    RW'(((64'd1 << K) + 64'(PERIOD) - 64'd1) / 64'(PERIOD));
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1) + 1;

  logic             a_v0, a_v1, a_ok;
  result_t          a_r0, a_r1;
  logic [SUM_W-1:0] a_sum;

  logic                 b_v0, b_v1, b_ok;
  result_t              b_r0, b_r1;
  logic [LO_W+RW-1:0]   b_plo;
  logic [HI_W+RW-1:0]   b_phi;

  result_t          queue [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  logic [PW-1:0]    prod;
  logic [PW-1:0]    quot;
  result_t          coarse_fix;
  logic             pop;
  logic [CNT_W-1:0] occupancy;
  logic [CNT_W-1:0] n_push;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v0 <= 1'b0;
      a_v1 <= 1'b0;
      b_v0 <= 1'b0;
      b_v1 <= 1'b0;
    end else begin
      a_v0 <= push.minute_valid;
      a_v1 <= push.coarse_valid;
      b_v0 <= a_v0;
      b_v1 <= a_v1;
    end
  end

  always_ff @(posedge clk) begin
    a_r0  <= push.minute_bar;
    a_r1  <= push.coarse_bar;
    a_ok  <= push.avg_ok;
    a_sum <= push_sum;
    b_r0  <= a_r0;
    b_r1  <= a_r1;
    b_ok  <= a_ok;
    b_plo <= (LO_W+RW)'(a_sum[LO_W-1:0]) * (LO_W+RW)'(RECIP);
    b_phi <= (HI_W+RW)'(a_sum[SUM_W-1:LO_W]) * (HI_W+RW)'(RECIP);
  end

  always_comb begin
    prod       = (PW'(b_phi) << LO_W) + PW'(b_plo);
    quot       = prod >> K;
    coarse_fix = b_r1;
    coarse_fix.moving_average = b_ok ? quot[30:0] : 31'd0;
    coarse_fix.average_valid  = b_ok;
  end

  assign out_valid = (count != '0);
  assign out_res   = queue[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign n_push    = CNT_W'(b_v0) + CNT_W'(b_v1);
  assign occupancy = count + CNT_W'(a_v0) + CNT_W'(a_v1) + CNT_W'(b_v0) + CNT_W'(b_v1);
  assign room      = (occupancy <= CNT_W'(QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (b_v0) begin
      queue[wr_ptr] <= b_r0;
    end
    if (b_v1) begin
      queue[wr_ptr + PTR_W'(1)] <= coarse_fix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + n_push - CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

// File: tb/tick_to_ohlc_bar_aggregator_test.sv
`timescale 1ns / 100ps
// Testbench for tick_to_ohlc_bar_aggregator: a directed table, then random
// minute sequences, checked against typed bars or a predictor of the bars.
// Depends on tohlc_pkg and the block's RTL.

module tick_to_ohlc_bar_aggregator_test;
  import tohlc_pkg::*;

  localparam int          CLOSE_WINDOW    = 10;
  localparam int          CYCLE_LIMIT     = 1_000_000;
  localparam int          IDLE_PAD        = 16;
  localparam int          HOLD_OFF_CYCLES = 400;
  localparam int          SCRIPT_ROWS     = 21;
  localparam int          PREDICTED       = -1;
  localparam logic [2:0]  ADDR_UNUSED     = 3'd4;
  localparam logic [30:0] PRICE_MAX       = 31'h7FFF_FFFF;
  localparam logic [31:0] VOL_MAX         = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [10:0] minute;
    logic [30:0] price;
    logic [31:0] volume;
  } tick_t;

  typedef struct {
    bit          resize;
    logic [5:0]  group_size;
    tick_t       tick;
    int          typed_n;
    result_t     typed_bar;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        tick_valid = 1'b0;
  logic        tick_ready;
  logic [10:0] minute_of_day = '0;
  logic [30:0] price = '0;
  logic [31:0] cum_volume = '0;
  logic        bar_valid;
  logic        bar_ready = 1'b0;
  logic        bar_kind;
  logic [10:0] start_minute;
  logic [30:0] open_price;
  logic [30:0] high_price;
  logic [30:0] low_price;
  logic [30:0] close_price;
  logic [31:0] bar_volume;
  logic [30:0] moving_average;
  logic        average_valid;
  logic        last_of_run;

  tick_to_ohlc_bar_aggregator #(.PERIOD(CLOSE_WINDOW)) u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .tick_valid(tick_valid), .tick_ready(tick_ready),
    .minute_of_day(minute_of_day), .price(price), .cum_volume(cum_volume),
    .bar_valid(bar_valid), .bar_ready(bar_ready),
    .bar_kind(bar_kind), .start_minute(start_minute),
    .open_price(open_price), .high_price(high_price), .low_price(low_price),
    .close_price(close_price), .bar_volume(bar_volume),
    .moving_average(moving_average), .average_valid(average_valid),
    .last_of_run(last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [5:0]  group_size;
  bit          bar_open;
  logic [10:0] cur_minute;
  logic [30:0] cur_open, cur_high, cur_low, cur_close;
  logic [31:0] cur_vol_first, cur_vol_last;
  logic [5:0]  grp_count;
  logic [10:0] grp_start, grp_prev;
  logic [30:0] grp_open, grp_high, grp_low;
  logic [31:0] grp_volume;
  logic [30:0] closes [CLOSE_WINDOW];
  int          ring_pos, ring_fill;
  logic [36:0] close_total;

  result_t     pending_bars [$];
  result_t     want;
  int          mismatches = 0;
  int          ticks_taken = 0;
  int          minute_bars = 0;
  int          coarse_bars = 0;
  int          averaged_bars = 0;
  int          sizes_used = 0;
  int          cycles = 0;
  int          stall_left = 0;
  int          rx_cycles = 0;
  bit          receiver_steady = 1'b0;
  bit          sender_steady = 1'b0;
  bit          squeeze_req = 1'b0;
  logic        squeeze = 1'b0;

  // random feed state
  logic [10:0] feed_minute = '0;
  longint      feed_price = 1_000_000;
  logic [31:0] feed_volume = '0;
  int          ticks_left = 0;
  int          break_pct = 5;
  int          max_ticks = 3;

  script_row_t script [SCRIPT_ROWS];

  function automatic void reset_bars();
    group_size = BARS_PER_GROUP_RESET;
    bar_open = 1'b0;
    cur_minute = '0; cur_open = '0; cur_high = '0; cur_low = '0; cur_close = '0;
    cur_vol_first = '0; cur_vol_last = '0;
    grp_count = '0; grp_start = '0; grp_prev = '0;
    grp_open = '0; grp_high = '0; grp_low = '0; grp_volume = '0;
    ring_pos = 0; ring_fill = 0; close_total = '0;
  endfunction

  function automatic void queue_bar(input result_t b);
    pending_bars = {pending_bars, b};
  endfunction

  function automatic void open_minute_bar(input tick_t t);
    bar_open = 1'b1;
    cur_minute = t.minute;
    cur_open = t.price; cur_high = t.price; cur_low = t.price; cur_close = t.price;
    cur_vol_first = t.volume; cur_vol_last = t.volume;
  endfunction

  function automatic int advance_bars(input tick_t t, output result_t bars [2]);
    logic [31:0] vol;
    logic [10:0] follow;
    logic [5:0]  need;
    logic [32:0] vsum;
    bit          full;
    bars[0] = '0;
    bars[1] = '0;
    if (!bar_open) begin
      open_minute_bar(t);
      return 0;
    end
    if (t.minute == cur_minute) begin
      if (t.price > cur_high) cur_high = t.price;
      if (t.price < cur_low) cur_low = t.price;
      cur_close = t.price;
      cur_vol_last = t.volume;
      return 0;
    end
    vol = (cur_vol_last >= cur_vol_first) ? cur_vol_last - cur_vol_first : '0;
    bars[0] = '{KIND_MINUTE, cur_minute, cur_open, cur_high, cur_low, cur_close, vol,
                31'd0, 1'b0, 1'b1};
    need = (group_size == 0) ? 6'd1 : group_size;
    follow = (grp_prev == LAST_MINUTE_OF_DAY) ? 11'd0 : grp_prev + 11'd1;
    if (grp_count != 0 && cur_minute != follow) grp_count = '0;
    if (grp_count == 0) begin
      grp_start = cur_minute;
      grp_open = cur_open;
      grp_high = cur_high;
      grp_low = cur_low;
      grp_volume = vol;
    end else begin
      if (cur_high > grp_high) grp_high = cur_high;
      if (cur_low < grp_low) grp_low = cur_low;
      vsum = {1'b0, grp_volume} + {1'b0, vol};
      grp_volume = vsum[32] ? VOL_MAX : vsum[31:0];
    end
    grp_prev = cur_minute;
    grp_count = grp_count + 6'd1;
    if (grp_count < need) begin
      open_minute_bar(t);
      return 1;
    end
    grp_count = '0;
    if (ring_fill >= CLOSE_WINDOW) close_total = close_total - closes[ring_pos];
    closes[ring_pos] = cur_close;
    close_total = close_total + cur_close;
    ring_pos = (ring_pos + 1) % CLOSE_WINDOW;
    if (ring_fill < CLOSE_WINDOW) ring_fill++;
    full = (ring_fill >= CLOSE_WINDOW);
    bars[0].last_of_run = 1'b0;
    bars[1] = '{KIND_COARSE, grp_start, grp_open, grp_high, grp_low, cur_close, grp_volume,
                full ? 31'(close_total / CLOSE_WINDOW) : 31'd0, full, 1'b1};
    open_minute_bar(t);
    return 2;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(15, 30);
  endfunction

  task automatic check_bar(input result_t exp_bar);
    if (bar_kind !== exp_bar.bar_kind) begin
      $error("bar_kind: expected %0d, got %0d", exp_bar.bar_kind, bar_kind);
      mismatches++;
    end
    if (start_minute !== exp_bar.start_minute) begin
      $error("start_minute: expected %0d, got %0d", exp_bar.start_minute, start_minute);
      mismatches++;
    end
    if (open_price !== exp_bar.open_price) begin
      $error("open_price: expected %0d, got %0d", exp_bar.open_price, open_price);
      mismatches++;
    end
    if (high_price !== exp_bar.high_price) begin
      $error("high_price: expected %0d, got %0d", exp_bar.high_price, high_price);
      mismatches++;
    end
    if (low_price !== exp_bar.low_price) begin
      $error("low_price: expected %0d, got %0d", exp_bar.low_price, low_price);
      mismatches++;
    end
    if (close_price !== exp_bar.close_price) begin
      $error("close_price: expected %0d, got %0d", exp_bar.close_price, close_price);
      mismatches++;
    end
    if (bar_volume !== exp_bar.bar_volume) begin
      $error("bar_volume: expected %0d, got %0d", exp_bar.bar_volume, bar_volume);
      mismatches++;
    end
    if (moving_average !== exp_bar.moving_average) begin
      $error("moving_average: expected %0d, got %0d", exp_bar.moving_average,
             moving_average);
      mismatches++;
    end
    if (average_valid !== exp_bar.average_valid) begin
      $error("average_valid: expected %0d, got %0d", exp_bar.average_valid, average_valid);
      mismatches++;
    end
    if (last_of_run !== exp_bar.last_of_run) begin
      $error("last_of_run: expected %0d, got %0d", exp_bar.last_of_run, last_of_run);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && bar_valid && bar_ready) begin
      if (pending_bars.size() == 0) begin
        $error("bar transaction with no expected bar waiting");
        mismatches++;
      end else begin
        want = pending_bars.pop_front();
        check_bar(want);
        if (want.bar_kind == KIND_COARSE) coarse_bars++;
        else minute_bars++;
        if (want.average_valid) averaged_bars++;
      end
    end
    rx_cycles++;
    if (rx_cycles % 400 == 0) receiver_steady = ($urandom_range(2) == 0);
    if (squeeze) begin
      bar_ready <= 1'b0;
    end else if (stall_left != 0) begin
      bar_ready <= 1'b0;
      stall_left--;
    end else begin
      bar_ready <= 1'b1;
      if (!receiver_steady && $urandom_range(99) < 25) stall_left = pick_gap();
    end
  end

  // hold the output side off for a long stretch so the block backs up
  initial begin
    wait (squeeze_req);
    @(posedge clk);
    squeeze <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    squeeze <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tick_to_ohlc_bar_aggregator test failed");
      $finish;
    end
  end

  task automatic apb_cycle(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                           output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_group_size();
    logic [31:0] rd;
    apb_cycle(1'b0, ADDR_BARS_PER_GROUP, '0, rd);
    if (rd !== {26'd0, group_size}) begin
      $error("bars_per_group: expected %0d, got %0d", group_size, rd);
      mismatches++;
    end
  endtask

  task automatic set_group_size(input logic [5:0] size);
    logic [31:0] rd;
    apb_cycle(1'b1, ADDR_BARS_PER_GROUP, {26'd0, size}, rd);
    group_size = size;
    sizes_used++;
    check_group_size();
  endtask

  task automatic offer_tick(input tick_t t);
    tick_valid <= 1'b1;
    minute_of_day <= t.minute;
    price <= t.price;
    cum_volume <= t.volume;
    do @(posedge clk); while (!tick_ready);
    ticks_taken++;
  endtask

  task automatic pause();
    int gap;
    gap = 0;
    if (!squeeze && !sender_steady && $urandom_range(99) < 35) gap = pick_gap();
    if (gap != 0) begin
      tick_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop valid, drain every expected bar, then let the pipeline empty
  task automatic settle();
    tick_valid <= 1'b0;
    while (pending_bars.size() != 0) @(posedge clk);
    repeat (IDLE_PAD) @(posedge clk);
  endtask

  task automatic make_tick(output tick_t t);
    int r;
    if (ticks_left == 0) begin
      r = $urandom_range(99);
      if (r < break_pct) begin
        if (r % 2 == 0) feed_minute = 11'($urandom_range(1430, 1439));
        else feed_minute = 11'($urandom_range(0, 2047));
      end else begin
        feed_minute = (feed_minute == LAST_MINUTE_OF_DAY) ? 11'd0 : feed_minute + 11'd1;
      end
      ticks_left = $urandom_range(1, max_ticks);
    end
    ticks_left--;
    r = $urandom_range(99);
    if (r < 4) begin
      feed_price = 0;
    end else if (r < 8) begin
      feed_price = longint'(PRICE_MAX);
    end else if (r < 18) begin
      feed_price = longint'($urandom & 32'h7FFF_FFFF);
    end else begin
      feed_price = feed_price + longint'($urandom_range(0, 2000)) - 1000;
      if (feed_price < 0) feed_price = 0;
      if (feed_price > longint'(PRICE_MAX)) feed_price = longint'(PRICE_MAX);
    end
    r = $urandom_range(99);
    if (r < 6) feed_volume = $urandom;
    else if (r < 9) feed_volume = VOL_MAX - $urandom_range(0, 50);
    else if (r < 11) feed_volume = '0;
    else feed_volume = feed_volume + $urandom_range(0, 5000);
    t = '{feed_minute, 31'(feed_price), feed_volume};
  endtask

  initial begin
    tick_t       t;
    result_t     made [2];
    int          n;
    int          random_items;
    int          phase_items;
    logic [5:0]  size;
    logic [5:0]  phase_sizes [6];
    logic [31:0] rd;

    script = '{
      '{1'b0, 6'd0, '{11'd0, PRICE_MAX, 32'd0}, 0, '0},
      '{1'b0, 6'd0, '{11'd0, 31'd0, VOL_MAX}, 0, '0},
      '{1'b0, 6'd0, '{11'd1, 31'd100, VOL_MAX}, 1,
        '{KIND_MINUTE, 11'd0, PRICE_MAX, PRICE_MAX, 31'd0, 31'd0, VOL_MAX, 31'd0, 1'b0, 1'b1}},
      '{1'b0, 6'd0, '{11'd2, 31'd50, 32'd10}, PREDICTED, '0},
      '{1'b0, 6'd0, '{11'd2, 31'd60, 32'd3}, 0, '0},
      '{1'b0, 6'd0, '{11'd2047, 31'd7, 32'd5}, 1,
        '{KIND_MINUTE, 11'd2, 31'd50, 31'd60, 31'd50, 31'd60, 32'd0, 31'd0, 1'b0, 1'b1}},
      '{1'b0, 6'd0, '{11'd2047, 31'd8, 32'd9}, PREDICTED, '0},
      '{1'b0, 6'd0, '{11'd0, 31'd9, 32'd9}, PREDICTED, '0},
      '{1'b0, 6'd0, '{11'd1439, 31'd20, 32'd40}, PREDICTED, '0},
      '{1'b0, 6'd0, '{11'd0, 31'd21, 32'd41}, PREDICTED, '0},
      '{1'b0, 6'd0, '{11'd5, 31'd22, 32'd42}, PREDICTED, '0},
      '{1'b0, 6'd0, '{11'd7, 31'd23, 32'd43}, PREDICTED, '0},
      '{1'b0, 6'd0, '{11'd9, 31'd24, 32'd44}, PREDICTED, '0},
      '{1'b1, 6'd0, '{11'd10, 31'd25, 32'd45}, PREDICTED, '0},
      '{1'b0, 6'd0, '{11'd11, 31'd26, 32'd46}, PREDICTED, '0},
      '{1'b1, 6'd5, '{11'd12, 31'd27, 32'd47}, PREDICTED, '0},
      '{1'b0, 6'd0, '{11'd13, 31'd28, 32'd48}, PREDICTED, '0},
      '{1'b0, 6'd0, '{11'd14, 31'd29, 32'd49}, PREDICTED, '0},
      '{1'b1, 6'd2, '{11'd15, 31'd30, 32'd50}, PREDICTED, '0},
      '{1'b1, 6'd60, '{11'd16, PRICE_MAX, VOL_MAX}, PREDICTED, '0},
      '{1'b0, 6'd0, '{11'd17, 31'd0, 32'd0}, PREDICTED, '0}
    };
    phase_sizes = '{6'd3, 6'd1, 6'd60, 6'd0, 6'd63, 6'd2};
    reset_bars();

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);
    check_group_size();

    foreach (script[i]) begin
      if (script[i].resize) begin
        settle();
        set_group_size(script[i].group_size);
      end
      offer_tick(script[i].tick);
      n = advance_bars(script[i].tick, made);
      if (script[i].typed_n == PREDICTED) begin
        for (int k = 0; k < n; k++) queue_bar(made[k]);
      end else if (script[i].typed_n == 1) begin
        queue_bar(script[i].typed_bar);
      end
      pause();
    end

    // a write to an address with no register leaves bars_per_group alone
    settle();
    apb_cycle(1'b1, ADDR_UNUSED, 32'h0000_003F, rd);
    check_group_size();

    feed_minute = cur_minute;
    random_items = 0;
    for (int ph = 0; ph < 8; ph++) begin
      size = (ph < 6) ? phase_sizes[ph] : 6'($urandom_range(1, 60));
      settle();
      set_group_size(size);
      phase_items = (size >= 20) ? 300 : 160;
      break_pct = (size >= 20) ? 0 : 5;
      max_ticks = (size >= 20) ? 2 : 3;
      for (int j = 0; j < phase_items; j++) begin
        if (j % 50 == 0) sender_steady = ($urandom_range(3) == 0);
        if (random_items == 250) squeeze_req = 1'b1;
        make_tick(t);
        offer_tick(t);
        n = advance_bars(t, made);
        for (int k = 0; k < n; k++) queue_bar(made[k]);
        random_items++;
        pause();
      end
    end

    settle();
    $display("%0d ticks over %0d group sizes: %0d minute bars, %0d coarse bars", ticks_taken,
             sizes_used, minute_bars, coarse_bars);
    $display("%0d coarse bars carried a valid average, %0d mismatches", averaged_bars,
             mismatches);
    if (mismatches == 0) begin
      $display("tick_to_ohlc_bar_aggregator test passed");
    end else begin
      $display("tick_to_ohlc_bar_aggregator test failed");
    end
    $finish;
  end

endmodule
